[rtl/ncpe_pkg.sv]
// ----------------------------------------------------------------------------
// ncpe_pkg
// Shared types and constants of the rational curve point evaluator.
// ----------------------------------------------------------------------------
package ncpe_pkg;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int WEIGHT_W = 24;
    localparam int KNOT_W   = 32;
    localparam int FRAC_W   = 17;
    localparam int SLOT_W   = 6;
    localparam int KIND_W   = 2;
    localparam int DEG_W    = 3;
    localparam int PCNT_W   = 6;

    // Fixed-point format of the basis values
    localparam int FRAC_BITS = 16;
    localparam int NBW       = FRAC_BITS + 1;
    localparam logic [NBW-1:0] ONE_B = NBW'(1) << FRAC_BITS;

    // Percent mapping
    localparam int PCT_SHIFT = 16;
    localparam logic [FRAC_W-1:0] PCT_WHOLE = FRAC_W'(65536);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_POINT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KNOT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PARAM   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PERCENT = 2'd3;

    // Configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'd1;
    localparam logic [DEG_W-1:0]  DEGREE_RST = 3'd3;
    localparam logic [PCNT_W-1:0] COUNT_RST  = 6'd4;

    // Shared divider
    localparam int DIV_W      = 64;
    localparam int DVS_W      = 32;
    localparam int DCNT_W     = 7;
    localparam int RAISE_BITS = KNOT_W + FRAC_BITS;  // basis term numerator magnitude
    localparam int QW         = RAISE_BITS + 1;      // signed basis term quotient
    localparam int ACC_W      = 64;

    // Output saturation bounds
    localparam logic [DIV_W-1:0]   POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [DIV_W-1:0]   NEG_LIMIT = 64'h0000_0000_8000_0000;
    localparam logic [COORD_W-1:0] SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_MIN   = 32'h8000_0000;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
        logic [DCNT_W-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

[rtl/nurbs_curve_point_evaluator.sv]
// Loads: written to the stores as they are accepted. An evaluation uses
//   K = n+p+1 knots; basis terms with a zero input skip the divider.
// Flow: one evaluation at a time; no input is taken until its result is
//   handed off. Each store has a single read port and the bit-serial
//   divider is shared. A finished result may wait.
// Reset: degree 3, point count 4, no result pending; stores are not cleared.
// ----------------------------------------------------------------------------
// nurbs_curve_point_evaluator
// Rational Cox-de Boor curve evaluation on stored points and knots, Q16.16.
// ----------------------------------------------------------------------------
module nurbs_curve_point_evaluator #(
    parameter int MAX_POINTS = 32,
    parameter int MAX_DEGREE = 7,
    parameter int MAX_KNOTS  = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ncpe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ncpe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ncpe_pkg::KIND_W-1:0]       i_kind,
    input  logic [ncpe_pkg::SLOT_W-1:0]       i_slot,
    input  logic signed [ncpe_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [ncpe_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [ncpe_pkg::COORD_W-1:0] i_coord_z,
    input  logic [ncpe_pkg::WEIGHT_W-1:0]     i_point_weight,
    input  logic [ncpe_pkg::KNOT_W-1:0]       i_knot_value,
    input  logic [ncpe_pkg::KNOT_W-1:0]       i_curve_param,
    input  logic [ncpe_pkg::FRAC_W-1:0]       i_fraction,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [ncpe_pkg::COORD_W-1:0] o_out_x,
    output logic signed [ncpe_pkg::COORD_W-1:0] o_out_y,
    output logic signed [ncpe_pkg::COORD_W-1:0] o_out_z,
    output logic                              o_denom_clamped
);
    import ncpe_pkg::*;

    localparam int NTAB = MAX_POINTS + MAX_DEGREE + 1;
    localparam int IW   = $clog2(MAX_POINTS + MAX_DEGREE + 2);
    localparam int BAW  = $clog2(NTAB);
    localparam int PAW  = $clog2(MAX_POINTS);
    localparam int KAW  = $clog2(MAX_KNOTS);
    localparam int DW   = $clog2(MAX_DEGREE + 1);
    localparam int PCW  = $clog2(MAX_POINTS + 1);
    localparam int DENW = WEIGHT_W + PAW;
    localparam int PT_W = 3 * COORD_W + WEIGHT_W;
    localparam int MW   = WEIGHT_W + COORD_W + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_WHOLE, S_LAST_RD, S_LAST_WT,
        S_B0_RA, S_B0_RB, S_B0_WR,
        S_R_RA, S_R_RB, S_R_RC, S_R_RD, S_R_RE, S_R_RF,
        S_T1, S_W1, S_T2, S_W2, S_SUM,
        S_A_RD, S_A_WB, S_A_MUL, S_A_ADD,
        S_DEN, S_DIV, S_DIV_WT, S_EMIT
    } t_state;

    t_state r_state;

    // configuration
    logic [DEG_W-1:0]  r_degree;
    logic [PCNT_W-1:0] r_point_count;
    logic [DW-1:0]     use_p;
    logic [PCW-1:0]    use_n;
    logic [IW-1:0]     use_k;

    // evaluation context
    logic [DW-1:0]     r_p;
    logic [DW-1:0]     r_d;
    logic [PCW-1:0]    r_n;
    logic [IW-1:0]     r_k;
    logic [IW-1:0]     r_i;
    logic              r_pct;
    logic [FRAC_W-1:0] r_frac;
    logic [KNOT_W-1:0] r_u;
    logic [KNOT_W-1:0] r_last;
    logic [KNOT_W-1:0] r_a;
    logic [KNOT_W-1:0] r_ui;
    logic [KNOT_W-1:0] r_ui1;
    logic [KNOT_W-1:0] r_uid;
    logic [KNOT_W-1:0] r_uid1;
    logic [NBW-1:0]    r_nlo;
    logic [NBW-1:0]    r_nhi;
    logic [QW-1:0]     r_q1;
    logic [QW-1:0]     r_q2;
    logic [WEIGHT_W-1:0] r_wb;
    logic signed [MW-1:0] r_mx;
    logic signed [MW-1:0] r_my;
    logic signed [MW-1:0] r_mz;
    logic [ACC_W-1:0]  r_acc_x;
    logic [ACC_W-1:0]  r_acc_y;
    logic [ACC_W-1:0]  r_acc_z;
    logic [DENW-1:0]   r_den;
    logic [1:0]        r_axis;
    logic [COORD_W-1:0] r_res_x;
    logic [COORD_W-1:0] r_res_y;
    logic [COORD_W-1:0] r_res_z;
    logic              r_res_flag;

    // output register
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [COORD_W-1:0] r_out_z;
    logic               r_out_flag;

    // memories
    logic [KNOT_W-1:0] mem_knot [MAX_KNOTS];
    logic [PT_W-1:0]   mem_pt   [MAX_POINTS];
    logic [NBW-1:0]    mem_nb   [NTAB];
    logic [KNOT_W-1:0] r_knot_q;
    logic              r_knot_oob;
    logic [PT_W-1:0]   r_pt_q;
    logic [NBW-1:0]    r_nb_q;

    logic              in_fire;
    logic              knot_we;
    logic              pt_we;
    logic              knot_re;
    logic [IW-1:0]     knot_idx;
    logic              pt_re;
    logic [IW-1:0]     pt_idx;
    logic              nb_re;
    logic [IW-1:0]     nb_ridx;
    logic              nb_we;
    logic [IW-1:0]     nb_widx;
    logic [NBW-1:0]    nb_wdata;
    logic [KNOT_W-1:0] kval;

    logic [COORD_W-1:0]  pt_x;
    logic [COORD_W-1:0]  pt_y;
    logic [COORD_W-1:0]  pt_z;
    logic [WEIGHT_W-1:0] pt_w;

    logic [KNOT_W+FRAC_W-1:0] pct_full;
    logic               b0_in;
    logic               t1_pos;
    logic               t1_neg;
    logic [KNOT_W-1:0]  t1_mag;
    logic [KNOT_W+NBW-1:0] t1_full;
    logic               t1_go;
    logic               t2_pos;
    logic               t2_neg;
    logic [KNOT_W-1:0]  t2_mag;
    logic [KNOT_W+NBW-1:0] t2_full;
    logic               t2_go;
    logic [QW:0]        sum;
    logic [NBW-1:0]     sum_clamped;
    logic [IW-1:0]      i_nxt;
    logic [NBW+WEIGHT_W-1:0] wb_full;
    logic [ACC_W-1:0]   acc_sel;
    logic               fin_neg;
    logic [DIV_W-1:0]   fin_mag;
    logic [COORD_W-1:0] fin_sat;
    logic [RAISE_BITS-1:0] q_mag;
    logic [QW-1:0]      q_signed_pos;
    logic [QW-1:0]      q_signed_neg;

    ncpe_pkg::t_div_req div_req;
    ncpe_pkg::t_div_rsp div_rsp;

    ncpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree      <= DEGREE_RST;
            r_point_count <= COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEGREE:      r_degree      <= i_cfg_data[DEG_W-1:0];
                CFG_POINT_COUNT: r_point_count <= i_cfg_data[PCNT_W-1:0];
            endcase
        end
    end

    // clamped configuration in use
    always_comb begin
        if (r_degree == '0) begin
            use_p = DW'(1);
        end else if (32'(r_degree) > MAX_DEGREE) begin
            use_p = DW'(MAX_DEGREE);
        end else begin
            use_p = DW'(r_degree);
        end
        if (32'(r_point_count) < 2) begin
            use_n = PCW'(2);
        end else if (32'(r_point_count) > MAX_POINTS) begin
            use_n = PCW'(MAX_POINTS);
        end else begin
            use_n = PCW'(r_point_count);
        end
        use_k = IW'(use_n) + IW'(use_p) + IW'(1);
    end

    // store writes from load items
    assign knot_we = in_fire && (i_kind == KIND_KNOT) && (32'(i_slot) < MAX_KNOTS);
    assign pt_we   = in_fire && (i_kind == KIND_POINT) && (32'(i_slot) < MAX_POINTS);

    // read addresses and basis writes per state
    always_comb begin
        knot_re  = 1'b0;
        knot_idx = '0;
        pt_re    = 1'b0;
        pt_idx   = '0;
        nb_re    = 1'b0;
        nb_ridx  = '0;
        nb_we    = 1'b0;
        nb_widx  = '0;
        nb_wdata = '0;
        unique case (r_state)
            S_IDLE: begin
                pt_re  = in_fire && (i_kind == KIND_PERCENT) && (i_fraction >= PCT_WHOLE);
                pt_idx = IW'(use_n) - IW'(1);
            end
            S_LAST_RD: begin
                knot_re  = 1'b1;
                knot_idx = r_k - IW'(1);
            end
            S_B0_RA: begin
                knot_re  = 1'b1;
                knot_idx = r_i;
            end
            S_B0_RB: begin
                knot_re  = 1'b1;
                knot_idx = r_i + IW'(1);
            end
            S_B0_WR: begin
                nb_we    = 1'b1;
                nb_widx  = r_i;
                nb_wdata = b0_in ? ONE_B : '0;
            end
            S_R_RA: begin
                knot_re  = 1'b1;
                knot_idx = r_i;
            end
            S_R_RB: begin
                knot_re  = 1'b1;
                knot_idx = r_i + IW'(1);
            end
            S_R_RC: begin
                knot_re  = 1'b1;
                knot_idx = r_i + IW'(r_d);
            end
            S_R_RD: begin
                knot_re  = 1'b1;
                knot_idx = r_i + IW'(r_d) + IW'(1);
                nb_re    = 1'b1;
                nb_ridx  = r_i;
            end
            S_R_RE: begin
                nb_re   = 1'b1;
                nb_ridx = r_i + IW'(1);
            end
            S_SUM: begin
                nb_we    = 1'b1;
                nb_widx  = r_i;
                nb_wdata = sum_clamped;
            end
            S_A_RD: begin
                pt_re   = 1'b1;
                pt_idx  = r_i;
                nb_re   = 1'b1;
                nb_ridx = r_i;
            end
            default: ;
        endcase
    end

    // knot store
    always_ff @(posedge i_clk) begin
        if (knot_we) begin
            mem_knot[KAW'(i_slot)] <= i_knot_value;
        end
        if (knot_re) begin
            r_knot_q   <= mem_knot[KAW'(knot_idx)];
            r_knot_oob <= 32'(knot_idx) >= MAX_KNOTS;
        end
    end

    // point store: x, y, z, weight packed in one entry
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            mem_pt[PAW'(i_slot)] <= {i_coord_x, i_coord_y, i_coord_z, i_point_weight};
        end
        if (pt_re) begin
            r_pt_q <= mem_pt[PAW'(pt_idx)];
        end
    end

    // basis working store; updated in place, each write lands before the next read
    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            mem_nb[BAW'(nb_widx)] <= nb_wdata;
        end
        if (nb_re) begin
            r_nb_q <= mem_nb[BAW'(nb_ridx)];
        end
    end

    assign kval = r_knot_oob ? '0 : r_knot_q;
    assign pt_x = r_pt_q[PT_W-1 -: COORD_W];
    assign pt_y = r_pt_q[PT_W-COORD_W-1 -: COORD_W];
    assign pt_z = r_pt_q[PT_W-2*COORD_W-1 -: COORD_W];
    assign pt_w = r_pt_q[WEIGHT_W-1:0];

    // percent parameter from the last knot
    assign pct_full = {{FRAC_W{1'b0}}, kval} * {{KNOT_W{1'b0}}, r_frac};

    // degree-0 span test, closed at the last knot
    assign b0_in = (r_u >= r_a && r_u < kval)
                || (r_u == r_last && r_a < kval && kval == r_last);

    // left term: (u - U[i]) * Nlow / (U[i+d] - U[i])
    assign t1_pos  = r_uid > r_ui;
    assign t1_neg  = r_u < r_ui;
    assign t1_mag  = t1_neg ? (r_ui - r_u) : (r_u - r_ui);
    assign t1_full = {{NBW{1'b0}}, t1_mag} * {{KNOT_W{1'b0}}, r_nlo};
    assign t1_go   = t1_pos && (r_nlo != '0);

    // right term: (U[i+d+1] - u) * Nhigh / (U[i+d+1] - U[i+1])
    assign t2_pos  = r_uid1 > r_ui1;
    assign t2_neg  = r_uid1 < r_u;
    assign t2_mag  = t2_neg ? (r_u - r_uid1) : (r_uid1 - r_u);
    assign t2_full = {{NBW{1'b0}}, t2_mag} * {{KNOT_W{1'b0}}, r_nhi};
    assign t2_go   = t2_pos && (r_nhi != '0);

    // quotient magnitude to signed term
    assign q_mag        = div_rsp.quot[RAISE_BITS-1:0];
    assign q_signed_pos = {1'b0, q_mag};
    assign q_signed_neg = QW'(0) - {1'b0, q_mag};

    // sum of both terms, clamped to [0, ONE]
    always_comb begin
        sum = {r_q1[QW-1], r_q1} + {r_q2[QW-1], r_q2};
        if (sum[QW]) begin
            sum_clamped = '0;
        end else if (sum[QW-1:0] > QW'(ONE_B)) begin
            sum_clamped = ONE_B;
        end else begin
            sum_clamped = sum[NBW-1:0];
        end
    end

    assign i_nxt   = r_i + IW'(1);
    assign wb_full = {{WEIGHT_W{1'b0}}, r_nb_q} * {{NBW{1'b0}}, pt_w};

    // final division operand and saturation
    always_comb begin
        unique case (r_axis)
            2'd0:    acc_sel = r_acc_x;
            2'd1:    acc_sel = r_acc_y;
            default: acc_sel = r_acc_z;
        endcase
        fin_neg = acc_sel[ACC_W-1];
        fin_mag = fin_neg ? (DIV_W'(0) - acc_sel) : acc_sel;
        if (fin_neg) begin
            fin_sat = (div_rsp.quot > NEG_LIMIT) ? SAT_MIN
                                                 : COORD_W'(DIV_W'(0) - div_rsp.quot);
        end else begin
            fin_sat = (div_rsp.quot > POS_LIMIT) ? SAT_MAX : div_rsp.quot[COORD_W-1:0];
        end
    end

    // divider request
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.nbits    = DCNT_W'(RAISE_BITS);
        unique case (r_state)
            S_T1: begin
                div_req.start    = t1_go;
                div_req.dividend = {t1_full[RAISE_BITS-1:0], {(DIV_W-RAISE_BITS){1'b0}}};
                div_req.divisor  = r_uid - r_ui;
            end
            S_T2: begin
                div_req.start    = t2_go;
                div_req.dividend = {t2_full[RAISE_BITS-1:0], {(DIV_W-RAISE_BITS){1'b0}}};
                div_req.divisor  = r_uid1 - r_ui1;
            end
            S_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = fin_mag;
                div_req.divisor  = DVS_W'(r_den);
                div_req.nbits    = DCNT_W'(DIV_W);
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // hand-off state refills the output register itself
            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_p <= use_p;
                        r_n <= use_n;
                        r_k <= use_k;
                        r_u <= i_curve_param;
                        r_frac <= i_fraction;
                        unique case (i_kind)
                            KIND_POINT, KIND_KNOT: r_state <= S_IDLE;
                            KIND_PARAM: begin
                                r_pct   <= 1'b0;
                                r_state <= S_LAST_RD;
                            end
                            KIND_PERCENT: begin
                                r_pct   <= 1'b1;
                                r_state <= (i_fraction >= PCT_WHOLE) ? S_WHOLE : S_LAST_RD;
                            end
                        endcase
                    end
                end
                S_WHOLE: begin
                    r_res_x    <= pt_x;
                    r_res_y    <= pt_y;
                    r_res_z    <= pt_z;
                    r_res_flag <= 1'b0;
                    r_state    <= S_EMIT;
                end
                S_LAST_RD: r_state <= S_LAST_WT;
                S_LAST_WT: begin
                    r_last <= kval;
                    if (r_pct) begin
                        r_u <= pct_full[PCT_SHIFT +: KNOT_W];
                    end
                    r_i     <= '0;
                    r_state <= S_B0_RA;
                end
                // degree-0 basis
                S_B0_RA: r_state <= S_B0_RB;
                S_B0_RB: begin
                    r_a     <= kval;
                    r_state <= S_B0_WR;
                end
                S_B0_WR: begin
                    if (i_nxt + IW'(1) < r_k) begin
                        r_i     <= i_nxt;
                        r_state <= S_B0_RA;
                    end else begin
                        r_i     <= '0;
                        r_d     <= DW'(1);
                        r_state <= S_R_RA;
                    end
                end
                // basis raise, one entry per pass
                S_R_RA: r_state <= S_R_RB;
                S_R_RB: begin
                    r_ui    <= kval;
                    r_state <= S_R_RC;
                end
                S_R_RC: begin
                    r_ui1   <= kval;
                    r_state <= S_R_RD;
                end
                S_R_RD: begin
                    r_uid   <= kval;
                    r_state <= S_R_RE;
                end
                S_R_RE: begin
                    r_uid1  <= kval;
                    r_nlo   <= r_nb_q;
                    r_state <= S_R_RF;
                end
                S_R_RF: begin
                    r_nhi   <= r_nb_q;
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_q1    <= '0;
                    r_state <= t1_go ? S_W1 : S_T2;
                end
                S_W1: begin
                    if (div_rsp.done) begin
                        r_q1    <= t1_neg ? q_signed_neg : q_signed_pos;
                        r_state <= S_T2;
                    end
                end
                S_T2: begin
                    r_q2    <= '0;
                    r_state <= t2_go ? S_W2 : S_SUM;
                end
                S_W2: begin
                    if (div_rsp.done) begin
                        r_q2    <= t2_neg ? q_signed_neg : q_signed_pos;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (i_nxt + IW'(r_d) + IW'(1) < r_k) begin
                        r_i     <= i_nxt;
                        r_state <= S_R_RA;
                    end else if (r_d == r_p) begin
                        r_i     <= '0;
                        r_acc_x <= '0;
                        r_acc_y <= '0;
                        r_acc_z <= '0;
                        r_den   <= '0;
                        r_state <= S_A_RD;
                    end else begin
                        r_i     <= '0;
                        r_d     <= r_d + DW'(1);
                        r_state <= S_R_RA;
                    end
                end
                // weighted sums over the points
                S_A_RD: r_state <= S_A_WB;
                S_A_WB: begin
                    r_wb    <= wb_full[FRAC_BITS +: WEIGHT_W];
                    r_state <= S_A_MUL;
                end
                S_A_MUL: begin
                    r_mx    <= $signed({1'b0, r_wb}) * $signed(pt_x);
                    r_my    <= $signed({1'b0, r_wb}) * $signed(pt_y);
                    r_mz    <= $signed({1'b0, r_wb}) * $signed(pt_z);
                    r_state <= S_A_ADD;
                end
                S_A_ADD: begin
                    r_acc_x <= r_acc_x + {{(ACC_W-MW){r_mx[MW-1]}}, r_mx};
                    r_acc_y <= r_acc_y + {{(ACC_W-MW){r_my[MW-1]}}, r_my};
                    r_acc_z <= r_acc_z + {{(ACC_W-MW){r_mz[MW-1]}}, r_mz};
                    r_den   <= r_den + DENW'(r_wb);
                    if (32'(i_nxt) < 32'(r_n)) begin
                        r_i     <= i_nxt;
                        r_state <= S_A_RD;
                    end else begin
                        r_state <= S_DEN;
                    end
                end
                // denominator clamp, then three divisions
                S_DEN: begin
                    if (r_den == '0) begin
                        r_den      <= DENW'(1);
                        r_res_flag <= 1'b1;
                    end else begin
                        r_res_flag <= 1'b0;
                    end
                    r_axis  <= 2'd0;
                    r_state <= S_DIV;
                end
                S_DIV: r_state <= S_DIV_WT;
                S_DIV_WT: begin
                    if (div_rsp.done) begin
                        unique case (r_axis)
                            2'd0:    r_res_x <= fin_sat;
                            2'd1:    r_res_y <= fin_sat;
                            default: r_res_z <= fin_sat;
                        endcase
                        if (r_axis == 2'd2) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_DIV;
                        end
                    end
                end
                // hand the result to the output register
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_res_x;
                        r_out_y     <= r_res_y;
                        r_out_z     <= r_res_z;
                        r_out_flag  <= r_res_flag;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_x         = r_out_x;
    assign o_out_y         = r_out_y;
    assign o_out_z         = r_out_z;
    assign o_denom_clamped = r_out_flag;

    // divider completes only while the sequencer waits for it
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_W1 || r_state == S_W2 || r_state == S_DIV_WT))
        else $error("divider finished outside a wait state");

    // no new division while one is running
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("division started while divider busy");

    // a result appears only from the hand-off state
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside hand-off");

    // a clamped denominator is exactly one LSB at hand-off
    a_clamp_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_res_flag) |-> (r_den == DENW'(1)))
        else $error("clamp flag without one-LSB denominator");

endmodule

[rtl/ncpe_div.sv]
// ----------------------------------------------------------------------------
// ncpe_div
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// The dividend is taken left aligned; nbits sets how many bits are consumed.
// ----------------------------------------------------------------------------
module ncpe_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ncpe_pkg::t_div_req i_req,
    output ncpe_pkg::t_div_rsp o_rsp
);
    import ncpe_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              fits;

    // trial subtract
    assign rem_sh  = {r_rem, r_dvd[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign fits    = rem_sh >= {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            r_rem <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule
